// ===== hw/rtl/rcfc_pkg.sv =====
// rcfc_pkg: shared types and constants of the remote command frame checker
// no dependencies; all other files of the block but rcfc_if refer to it by scoped names
`default_nettype none

package rcfc_pkg;

  // sizing defaults handed to the top level parameters
  localparam int MAX_PAYLOAD_BYTES = 32;
  localparam int QUEUE_DEPTH       = 4;

  // raw stick full scale, a power of two so the scaling divide is a shift
  localparam int RAW_FULL_SCALE = 4096;
  localparam int RAW_SHIFT      = $clog2(RAW_FULL_SCALE);

  // frame header bytes
  localparam logic [7:0] HDR_FIRST  = 8'h24;
  localparam logic [7:0] HDR_SECOND = 8'h4D;

  // elapsed tick counter saturates here
  localparam int             ELAPSED_W   = 17;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // configuration reset values
  localparam logic [5:0]  MESSAGE_LENGTH_RST = 6'd10;
  localparam logic [9:0]  MAX_SPEED_RST      = 10'd100;
  localparam logic [9:0]  MAX_TURNING_RST    = 10'd100;
  localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd500;

  // configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MESSAGE_LENGTH = 3'd0,
    REG_MAX_SPEED      = 3'd1,
    REG_MAX_TURNING    = 3'd2,
    REG_TIMEOUT_TICKS  = 3'd3
  } rcfc_reg_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CHECKSUM = 3'd2,
    ST_HEADER   = 3'd3,
    ST_TIMEOUT  = 3'd4
  } rcfc_status_t;

  // configuration registers as seen by front and back
  typedef struct packed {
    logic [5:0]  message_length;
    logic [9:0]  max_speed;
    logic [9:0]  max_turning;
    logic [15:0] timeout_ticks;
  } rcfc_cfg_t;

  // classified frame or timeout, queued between front and back
  typedef struct packed {
    rcfc_status_t status;
    logic         idle_request;
    logic [15:0]  speed_raw;
    logic [15:0]  turning_raw;
  } rcfc_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcfc_if.sv =====
// rcfc_in_if and rcfc_out_if: valid/ready channels of the frame checker
// depends on nothing; field widths follow the block's item definitions
`default_nettype none

interface rcfc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output kind, output byte_value, output last_byte,
                  input ready);
  modport sink   (input valid, input kind, input byte_value, input last_byte,
                  output ready);
endinterface

interface rcfc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               idle_request;
  logic signed [15:0] speed;
  logic signed [15:0] turning;

  modport source (output valid, output status, output idle_request, output speed,
                  output turning, input ready);
  modport sink   (input valid, input status, input idle_request, input speed,
                  input turning, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/remote_command_frame_checker.sv =====
// remote_command_frame_checker: top level, config registers and front/queue/back
// depends on rcfc_pkg, rcfc_if, rcfc_front, rcfc_queue, rcfc_back
//
//  channel  dir  handshake         beat contents
//  in_ch    in   valid/ready       kind, byte_value, last_byte
//  out_ch   out  valid/ready       status, idle_request, speed, turning
//  cfg      in   cfg_we (no wait)  cfg_index, cfg_wdata
//
//  one input beat per cycle while the queue is not full; the front classifies a byte or tick in its accept cycle
//  a result passes from its input beat through the queue, multiply stage and result register
//  the queue of QUEUE_DEPTH items lets input flow while the result side is stalled
//  in_ch.ready drops only when the queue is full; no clearing pass after reset
//  synchronous active-high reset restores register defaults and an empty frame
`default_nettype none

module remote_command_frame_checker #(
  parameter int MAX_PAYLOAD_BYTES = rcfc_pkg::MAX_PAYLOAD_BYTES,
  parameter int QUEUE_DEPTH       = rcfc_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  rcfc_in_if.sink                          in_ch,
  rcfc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [rcfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rcfc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  rcfc_pkg::rcfc_cfg_t  cfg;
  rcfc_pkg::rcfc_item_t push_item, pop_item;
  logic                 push, pop, q_full, q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.message_length <= rcfc_pkg::MESSAGE_LENGTH_RST;
      cfg.max_speed      <= rcfc_pkg::MAX_SPEED_RST;
      cfg.max_turning    <= rcfc_pkg::MAX_TURNING_RST;
      cfg.timeout_ticks  <= rcfc_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcfc_pkg::REG_MESSAGE_LENGTH: cfg.message_length <= cfg_wdata[5:0];
        rcfc_pkg::REG_MAX_SPEED:      cfg.max_speed      <= cfg_wdata[9:0];
        rcfc_pkg::REG_MAX_TURNING:    cfg.max_turning    <= cfg_wdata[9:0];
        rcfc_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  rcfc_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_item(push_item)
  );

  rcfc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (pop),
    .pop_item (pop_item),
    .empty    (q_empty)
  );

  rcfc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_empty(q_empty),
    .q_item (pop_item),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rcfc_front.sv =====
// rcfc_front: accepts bytes and ticks, tracks frame fields, classifies frames
// depends on rcfc_pkg and rcfc_in_if; pushes one item per result into the queue
`default_nettype none

module rcfc_front #(
  parameter int MAX_PAYLOAD_BYTES = rcfc_pkg::MAX_PAYLOAD_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  rcfc_pkg::rcfc_cfg_t cfg,
  rcfc_in_if.sink             in_ch,
  input  logic                q_full,
  output logic                push,
  output rcfc_pkg::rcfc_item_t push_item
);

  localparam int PW = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int CW = (PW > 9) ? PW : 9;

  localparam logic [PW-1:0] POS_HDR_FIRST  = PW'(0);
  localparam logic [PW-1:0] POS_HDR_SECOND = PW'(1);
  localparam logic [PW-1:0] POS_LENGTH     = PW'(3);
  localparam logic [PW-1:0] POS_TURN_HI    = PW'(5);
  localparam logic [PW-1:0] POS_TURN_LO    = PW'(6);
  localparam logic [PW-1:0] POS_SPEED_HI   = PW'(7);
  localparam logic [PW-1:0] POS_SPEED_LO   = PW'(8);

  // frame state
  logic [PW-1:0]                 pos;
  logic [7:0]                    running_xor, length_byte, header_first, header_second;
  logic [7:0]                    check_byte;
  logic [15:0]                   turning_raw, speed_raw;
  logic [rcfc_pkg::ELAPSED_W-1:0] elapsed;

  logic                          accept, first, in_range;
  logic [PW-1:0]                 pos_inc, count;
  logic [7:0]                    b;
  logic [7:0]                    xor_next, length_next, hfirst_next, hsecond_next, check_next;
  logic [15:0]                   turning_next, speed_next;
  logic [rcfc_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic                          late, tick_late, is_short, bad_sum, bad_hdr;
  rcfc_pkg::rcfc_status_t        frame_status;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_value;

  // per-byte field update, fields read as zero at the first byte of a frame
  always_comb begin
    first    = (pos == '0);
    in_range = CW'(pos) < CW'(MAX_PAYLOAD_BYTES);
    pos_inc  = pos + 1'b1;

    xor_next     = first ? 8'h00 : running_xor;
    length_next  = first ? 8'h00 : length_byte;
    hfirst_next  = first ? 8'h00 : header_first;
    hsecond_next = first ? 8'h00 : header_second;
    check_next   = first ? 8'h00 : check_byte;
    turning_next = first ? 16'h0000 : turning_raw;
    speed_next   = first ? 16'h0000 : speed_raw;

    if (in_range) begin
      if (pos == POS_LENGTH) length_next = b;
      if (pos >= POS_LENGTH && (CW'(pos) + CW'(2) <= CW'(length_next))) begin
        xor_next = xor_next ^ b;
      end
      if (pos == POS_HDR_FIRST)  hfirst_next  = b;
      if (pos == POS_HDR_SECOND) hsecond_next = b;
      if (pos == POS_TURN_HI)    turning_next = {b, turning_next[7:0]};
      if (pos == POS_TURN_LO)    turning_next = {turning_next[15:8], b};
      if (pos == POS_SPEED_HI)   speed_next   = {b, speed_next[7:0]};
      if (pos == POS_SPEED_LO)   speed_next   = {speed_next[15:8], b};
      if (CW'(pos_inc) == CW'(cfg.message_length)) check_next = b;
    end
    count = in_range ? pos_inc : pos;
  end

  // frame checks in priority order, timeout tests
  always_comb begin
    elapsed_inc = (elapsed == rcfc_pkg::ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
    tick_late   = elapsed_inc > rcfc_pkg::ELAPSED_W'(cfg.timeout_ticks);
    late        = elapsed > rcfc_pkg::ELAPSED_W'(cfg.timeout_ticks);
    is_short    = CW'(count) < CW'(cfg.message_length);
    bad_sum     = check_next != xor_next;
    bad_hdr     = hfirst_next != rcfc_pkg::HDR_FIRST || hsecond_next != rcfc_pkg::HDR_SECOND;
    priority if (is_short) frame_status = rcfc_pkg::ST_SHORT;
    else if (bad_sum)      frame_status = rcfc_pkg::ST_CHECKSUM;
    else if (bad_hdr)      frame_status = rcfc_pkg::ST_HEADER;
    else                   frame_status = rcfc_pkg::ST_OK;
  end

  // queue push
  always_comb begin
    push_item = '0;
    push      = 1'b0;
    if (accept) begin
      if (in_ch.kind) begin
        push                   = tick_late;
        push_item.status       = rcfc_pkg::ST_TIMEOUT;
        push_item.idle_request = 1'b1;
      end else begin
        push                   = in_ch.last_byte;
        push_item.status       = frame_status;
        push_item.idle_request = (frame_status == rcfc_pkg::ST_SHORT ||
                                  frame_status == rcfc_pkg::ST_CHECKSUM) && late;
        push_item.speed_raw    = speed_next;
        push_item.turning_raw  = turning_next;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      elapsed <= '0;
    end else if (accept) begin
      if (in_ch.kind) begin
        elapsed <= elapsed_inc;
      end else begin
        pos <= in_ch.last_byte ? '0 : count;
        if (in_ch.last_byte && frame_status == rcfc_pkg::ST_OK) elapsed <= '0;
      end
    end
  end

  // frame fields
  always_ff @(posedge clk) begin
    if (accept && !in_ch.kind) begin
      running_xor   <= xor_next;
      length_byte   <= length_next;
      header_first  <= hfirst_next;
      header_second <= hsecond_next;
      check_byte    <= check_next;
      turning_raw   <= turning_next;
      speed_raw     <= speed_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rcfc_queue.sv =====
// rcfc_queue: short item queue between the classifying front and scaling back
// depends on rcfc_pkg for the item type
`default_nettype none

module rcfc_queue #(
  parameter int DEPTH = rcfc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rcfc_pkg::rcfc_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output rcfc_pkg::rcfc_item_t pop_item,
  output logic                 empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  rcfc_pkg::rcfc_item_t entries [DEPTH];
  logic [AW-1:0]        wr_ptr, rd_ptr;
  logic [NW-1:0]        fill;
  logic                 do_pop;

  assign full     = (fill == NW'(DEPTH));
  assign empty    = (fill == '0);
  assign do_pop   = pop && !empty;
  assign pop_item = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push)   wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !do_pop)      fill <= fill + 1'b1;
      else if (!push && do_pop) fill <= fill - 1'b1;
    end
  end

  // front only pushes while there is room
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");

  // fill level stays within depth
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= NW'(DEPTH))
    else $error("queue fill out of range");

  // a pop with nothing pushed lowers the fill by one
  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
      (do_pop && !push) |=> fill == $past(fill) - 1'b1)
    else $error("queue fill not lowered on pop");

endmodule

`default_nettype wire

// ===== hw/rtl/rcfc_back.sv =====
// rcfc_back: scales speed and turning of accepted frames, drives the result beat
// depends on rcfc_pkg and rcfc_out_if; pops items from rcfc_queue
`default_nettype none

module rcfc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rcfc_pkg::rcfc_cfg_t  cfg,
  input  logic                 q_empty,
  input  rcfc_pkg::rcfc_item_t q_item,
  output logic                 pop,
  rcfc_out_if.source           out_ch
);

  localparam int PRW = 30;
  localparam logic signed [PRW-1:0] ROUND_NEG = PRW'(rcfc_pkg::RAW_FULL_SCALE - 1);
  localparam logic signed [PRW-1:0] NO_ROUND  = '0;
  localparam logic signed [PRW-1:0] SAT_HI    = PRW'(32767);
  localparam logic signed [PRW-1:0] SAT_LO    = -PRW'(32768);

  // multiply stage
  logic                   s1_valid, s1_idle;
  rcfc_pkg::rcfc_status_t s1_status;
  logic signed [PRW-1:0]  s1_prod_speed, s1_prod_turn;

  logic                   adv1, adv2;
  logic signed [17:0]     x_speed, x_turn;
  logic signed [10:0]     span_speed, span_turn;
  logic signed [15:0]     speed_scaled, turn_scaled;

  assign adv2 = !out_ch.valid || out_ch.ready;
  assign adv1 = !s1_valid || adv2;
  assign pop  = adv1 && !q_empty;

  // raw operands: speed as is, turning inverted against full scale
  always_comb begin
    x_speed    = $signed({2'b00, q_item.speed_raw});
    x_turn     = 18'(rcfc_pkg::RAW_FULL_SCALE) - $signed({2'b00, q_item.turning_raw});
    span_speed = $signed({1'b0, cfg.max_speed});
    span_turn  = $signed({1'b0, cfg.max_turning});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_status     <= q_item.status;
      s1_idle       <= q_item.idle_request;
      s1_prod_speed <= (PRW'(x_speed) * PRW'(span_speed)) <<< 1;
      s1_prod_turn  <= (PRW'(x_turn) * PRW'(span_turn)) <<< 1;
    end
  end

  // truncating divide by full scale, offset by span, saturate to 16 bits
  function automatic logic signed [15:0] finish(input logic signed [PRW-1:0] prod,
                                                input logic [9:0] span);
    logic signed [PRW-1:0] q;
    logic signed [PRW-1:0] v;
    q = (prod + ((prod < 0) ? ROUND_NEG : NO_ROUND)) >>> rcfc_pkg::RAW_SHIFT;
    v = q - $signed({{(PRW - 10){1'b0}}, span});
    if (v > SAT_HI)      finish = 16'sh7FFF;
    else if (v < SAT_LO) finish = 16'sh8000;
    else                 finish = v[15:0];
  endfunction

  assign speed_scaled = finish(s1_prod_speed, cfg.max_speed);
  assign turn_scaled  = finish(s1_prod_turn, cfg.max_turning);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv2) begin
      out_ch.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      out_ch.status       <= s1_status;
      out_ch.idle_request <= s1_idle;
      out_ch.speed        <= (s1_status == rcfc_pkg::ST_OK) ? speed_scaled : 16'sd0;
      out_ch.turning      <= (s1_status == rcfc_pkg::ST_OK) ? turn_scaled : 16'sd0;
    end
  end

  // timeout beats always request idle
  a_timeout_idle: assert property (@(posedge clk) disable iff (rst)
      (out_ch.valid && out_ch.status == rcfc_pkg::ST_TIMEOUT) |-> out_ch.idle_request)
    else $error("timeout beat without idle request");

  // accepted or bad-header frames never request idle
  a_ok_no_idle: assert property (@(posedge clk) disable iff (rst)
      (out_ch.valid && (out_ch.status == rcfc_pkg::ST_OK ||
                        out_ch.status == rcfc_pkg::ST_HEADER)) |-> !out_ch.idle_request)
    else $error("idle request on accepted or header error beat");

  // rejected beats carry no motion
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
      (out_ch.valid && out_ch.status != rcfc_pkg::ST_OK) |->
        (out_ch.speed == 16'sd0 && out_ch.turning == 16'sd0))
    else $error("motion on rejected beat");

  // a stalled multiply stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
      (s1_valid && !adv2) |=> (s1_valid && $stable(s1_prod_speed) && $stable(s1_status)))
    else $error("multiply stage lost item under stall");

endmodule

`default_nettype wire
